// ===== rtl/estm_pkg.sv =====
package estm_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int STAMP_BITS_DEF = 32;
  localparam int REF_BITS_DEF   = 8;

  // Wide enough to name any slot up to the largest table size.
  localparam int SEL_W  = 8;
  localparam int CNT_W  = 5;
  localparam int FUNC_W = 4;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 4'd0;
  localparam logic [FUNC_W-1:0] FN_READY   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_DISCARD = 4'd2;
  localparam logic [FUNC_W-1:0] FN_REFSPEC = 4'd3;
  localparam logic [FUNC_W-1:0] FN_REFNEXT = 4'd4;
  localparam logic [FUNC_W-1:0] FN_DEREF   = 4'd5;
  localparam logic [FUNC_W-1:0] FN_COUNT   = 4'd6;
  localparam logic [FUNC_W-1:0] FN_READ    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLRW    = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTREADY = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  typedef enum logic [2:0] {
    CM_ALLOC   = 3'd0,
    CM_READY   = 3'd1,
    CM_DISCARD = 3'd2,
    CM_INC     = 3'd3,
    CM_DEREF   = 3'd4,
    CM_CLRW    = 3'd5
  } cm_kind_t;

  typedef struct packed {
    logic             en;
    cm_kind_t         kind;
    logic [SEL_W-1:0] idx;
  } cmt_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             inv;
    logic             found;
    logic             rv;
    logic             rw;
    logic [SEL_W-1:0] pick;
    logic [CNT_W-1:0] cnt;
  } tok_t;

endpackage

// ===== rtl/event_slot_table_manager.sv =====
// Channel | Ports  | tuser          | tdata
// input   | in_*   | func           | slot_sel, stamp_lo, stamp_hi
// result  | out_*  | status         | result_index, event_count, read_valid,
//         |        |                | read_writing, read_refcount, read_stamp
//
// After a beat is accepted, the search token walks the row of slot cells one cell per
// cycle, then the chosen update is committed as the result is registered. The block
// returns to idle as the result is registered, ready to take the next beat.
// One request is handled at a time; a new request is taken while the previous
// result still waits in the output register.
// A stalled result holds the next request in its final step until it is taken.
// Reset is synchronous and clears every slot.
module event_slot_table_manager #(
  parameter int NUM_SLOTS  = estm_pkg::NUM_SLOTS_DEF,
  parameter int STAMP_BITS = estm_pkg::STAMP_BITS_DEF,
  parameter int REF_BITS   = estm_pkg::REF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // func[3:0]
  input  logic [71:0] in_tdata,   // slot_sel[3:0], stamp_lo[35:4], stamp_hi[67:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic [55:0] out_tdata   // result_index[3:0], event_count[8:4], read_valid[9],
                                  // read_writing[10], read_refcount[18:11],
                                  // read_stamp[50:19]
);
  import estm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r;
  logic [SEL_W-1:0]      idx_r;
  logic [STAMP_BITS-1:0] ts_r, ul_r;
  logic                  start_r;
  tok_t                  fin_tok_r;
  logic [STAMP_BITS-1:0] fin_best_r;
  logic [REF_BITS-1:0]   fin_prefs_r;
  logic                  out_valid_r;
  logic [1:0]            out_user_r;
  logic [55:0]           out_data_r;

  tok_t                  tok   [NUM_SLOTS+1];
  logic [STAMP_BITS-1:0] best  [NUM_SLOTS+1];
  logic [REF_BITS-1:0]   prefs [NUM_SLOTS+1];

  cmt_t                  cmt;
  logic                  accept, finish, in_range, ready_hit, refs_full;
  logic [STAT_W-1:0]     status;
  logic [3:0]            rindex;
  logic [CNT_W-1:0]      count;
  logic                  rv, rw;
  logic [7:0]            rrefs;
  logic [31:0]           rstamp;
  logic [63:0]           ts_ext, ul_ext, stamp_ext;
  logic [15:0]           refs_ext;

  assign accept = (state_r == S_IDLE) && in_tvalid;
  assign finish = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  assign ts_ext = {32'b0, in_tdata[35:4]};
  assign ul_ext = {32'b0, in_tdata[67:36]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (tok[NUM_SLOTS].valid) state_nxt = S_FIN;
      S_FIN:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
    if (accept) begin
      func_r <= in_tuser;
      idx_r  <= SEL_W'(in_tdata[3:0]);
      ts_r   <= ts_ext[STAMP_BITS-1:0];
      ul_r   <= ul_ext[STAMP_BITS-1:0];
    end
    if (state_r == S_SCAN && tok[NUM_SLOTS].valid) begin
      fin_tok_r   <= tok[NUM_SLOTS];
      fin_best_r  <= best[NUM_SLOTS];
      fin_prefs_r <= prefs[NUM_SLOTS];
    end
  end

  // The head of the row starts the token with the lower search bound.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_r;
    best[0]      = ts_r;
    prefs[0]     = '0;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    estm_cell #(
      .CELL_ID   (g),
      .STAMP_BITS(STAMP_BITS),
      .REF_BITS  (REF_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .func     (func_r),
      .sel      (idx_r),
      .ts       (ts_r),
      .ul       (ul_r),
      .tok_in   (tok[g]),
      .best_in  (best[g]),
      .prefs_in (prefs[g]),
      .tok_out  (tok[g+1]),
      .best_out (best[g+1]),
      .prefs_out(prefs[g+1]),
      .cmt      (cmt)
    );
  end

  assign in_range  = {1'b0, idx_r} < (SEL_W+1)'(NUM_SLOTS);
  assign ready_hit = fin_tok_r.rv & ~fin_tok_r.rw;
  assign refs_full = &fin_prefs_r;
  assign stamp_ext = 64'(fin_best_r);
  assign refs_ext  = 16'(fin_prefs_r);

  always_comb begin
    status   = ST_OK;
    rindex   = '0;
    count    = '0;
    rv       = 1'b0;
    rw       = 1'b0;
    rrefs    = '0;
    rstamp   = '0;
    cmt      = '0;
    cmt.kind = CM_ALLOC;
    case (func_r)
      FN_ALLOC: begin
        if (fin_tok_r.found) begin
          rindex   = fin_tok_r.pick[3:0];
          cmt.en   = finish;
          cmt.kind = CM_ALLOC;
          cmt.idx  = fin_tok_r.pick;
        end else begin
          status = ST_NOTFOUND;
        end
      end
      FN_READY, FN_DISCARD, FN_DEREF: begin
        if (!in_range) begin
          status = ST_NOTFOUND;
        end else begin
          cmt.en  = finish;
          cmt.idx = idx_r;
          if (func_r == FN_READY) begin
            cmt.kind = CM_READY;
          end else if (func_r == FN_DISCARD) begin
            cmt.kind = CM_DISCARD;
          end else begin
            cmt.kind = CM_DEREF;
          end
        end
      end
      FN_REFSPEC: begin
        if (!in_range) begin
          status = ST_NOTFOUND;
        end else if (!ready_hit) begin
          status = ST_NOTREADY;
        end else if (refs_full) begin
          status = ST_OVERFLOW;
        end else begin
          cmt.en   = finish;
          cmt.kind = CM_INC;
          cmt.idx  = idx_r;
        end
      end
      FN_REFNEXT: begin
        if (!fin_tok_r.found) begin
          status = ST_NOTFOUND;
        end else begin
          rindex = fin_tok_r.pick[3:0];
          if (refs_full) begin
            status = ST_OVERFLOW;
          end else begin
            cmt.en   = finish;
            cmt.kind = CM_INC;
            cmt.idx  = fin_tok_r.pick;
          end
        end
      end
      FN_COUNT: count = fin_tok_r.cnt;
      FN_READ: begin
        if (!in_range) begin
          status = ST_NOTFOUND;
        end else begin
          rv     = fin_tok_r.rv;
          rw     = fin_tok_r.rw;
          rrefs  = refs_ext[7:0];
          rstamp = stamp_ext[31:0];
        end
      end
      FN_CLRW: begin
        cmt.en   = finish;
        cmt.kind = CM_CLRW;
      end
      default: status = ST_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (finish) begin
      out_user_r <= status;
      out_data_r <= {5'b0, rstamp, rrefs, rw, rv, count, rindex};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/estm_cell.sv =====
module estm_cell #(
  parameter int CELL_ID    = 0,
  parameter int STAMP_BITS = estm_pkg::STAMP_BITS_DEF,
  parameter int REF_BITS   = estm_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [estm_pkg::FUNC_W-1:0]     func,
  input  logic [estm_pkg::SEL_W-1:0]      sel,
  input  logic [STAMP_BITS-1:0]           ts,
  input  logic [STAMP_BITS-1:0]           ul,
  input  estm_pkg::tok_t                  tok_in,
  input  logic [STAMP_BITS-1:0]           best_in,
  input  logic [REF_BITS-1:0]             prefs_in,
  output estm_pkg::tok_t                  tok_out,
  output logic [STAMP_BITS-1:0]           best_out,
  output logic [REF_BITS-1:0]             prefs_out,
  input  estm_pkg::cmt_t                  cmt
);
  import estm_pkg::*;

  localparam logic [SEL_W-1:0] MY_ID = SEL_W'(CELL_ID);

  logic                  valid_r, writing_r;
  logic [REF_BITS-1:0]   refs_r;
  logic [STAMP_BITS-1:0] stamp_r;
  tok_t                  tok_r, tok_nxt;
  logic [STAMP_BITS-1:0] best_r, best_nxt;
  logic [REF_BITS-1:0]   prefs_r, prefs_nxt;
  logic                  ready, hit, cm_hit;

  assign ready  = valid_r & ~writing_r;
  assign hit    = (sel == MY_ID);
  assign cm_hit = (cmt.idx == MY_ID);

  always_comb begin
    tok_nxt   = tok_in;
    best_nxt  = best_in;
    prefs_nxt = prefs_in;
    case (func)
      FN_ALLOC: begin
        if (!tok_in.inv) begin
          if (!valid_r) begin
            tok_nxt.inv   = 1'b1;
            tok_nxt.found = 1'b1;
            tok_nxt.pick  = MY_ID;
          end else if (refs_r == '0 && !writing_r &&
                       (!tok_in.found || stamp_r < best_in)) begin
            tok_nxt.found = 1'b1;
            tok_nxt.pick  = MY_ID;
            best_nxt      = stamp_r;
          end
        end
      end
      FN_REFNEXT: begin
        // The best stamp so far becomes the new lower bound.
        if (ready && stamp_r > best_in && stamp_r < ul) begin
          tok_nxt.found = 1'b1;
          tok_nxt.pick  = MY_ID;
          best_nxt      = stamp_r;
          prefs_nxt     = refs_r;
        end
      end
      FN_COUNT: begin
        if (ready && stamp_r > ts && tok_in.cnt != CNT_MAX) begin
          tok_nxt.cnt = tok_in.cnt + CNT_W'(1);
        end
      end
      default: begin
        if (hit) begin
          tok_nxt.rv = valid_r;
          tok_nxt.rw = writing_r;
          prefs_nxt  = refs_r;
          best_nxt   = stamp_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    best_r  <= best_nxt;
    prefs_r <= prefs_nxt;
  end

  assign tok_out   = tok_r;
  assign best_out  = best_r;
  assign prefs_out = prefs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      writing_r <= 1'b0;
      refs_r    <= '0;
      stamp_r   <= '0;
    end else if (cmt.en) begin
      case (cmt.kind)
        CM_ALLOC: begin
          if (cm_hit) begin
            valid_r   <= 1'b1;
            writing_r <= 1'b1;
            refs_r    <= '0;
            stamp_r   <= '0;
          end
        end
        CM_READY: begin
          if (cm_hit) begin
            valid_r   <= 1'b1;
            writing_r <= 1'b0;
            refs_r    <= '0;
            stamp_r   <= ts;
          end
        end
        CM_DISCARD: begin
          if (cm_hit && writing_r) begin
            valid_r   <= 1'b0;
            writing_r <= 1'b0;
            refs_r    <= '0;
            stamp_r   <= '0;
          end
        end
        CM_INC: begin
          if (cm_hit) begin
            refs_r <= refs_r + REF_BITS'(1);
          end
        end
        CM_DEREF: begin
          if (cm_hit && refs_r != '0) begin
            refs_r <= refs_r - REF_BITS'(1);
          end
        end
        CM_CLRW: begin
          if (writing_r) begin
            valid_r   <= 1'b0;
            writing_r <= 1'b0;
            refs_r    <= '0;
            stamp_r   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/estm_checker.sv =====
module estm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [3:0]  in_tuser,
  input logic [71:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [1:0]  out_tuser,
  input logic [55:0] out_tdata
);
  import estm_pkg::*;

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A failed search never names a slot.
  a_notfound_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NOTFOUND |-> out_tdata[3:0] == 4'd0)
    else $error("failed request reports a slot");

  // A count result carries nothing else.
  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:4] != 5'd0 |->
      out_tuser == ST_OK && out_tdata[3:0] == 4'd0 && out_tdata[55:9] == '0)
    else $error("count result mixed with other fields");

endmodule

bind event_slot_table_manager estm_checker u_estm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tuser (out_tuser),
  .out_tdata (out_tdata)
);

// ===== bench/tb_event_slot_table_manager.sv =====
module tb_event_slot_table_manager;
  timeunit 1ns;
  timeprecision 1ps;
  import estm_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  slot;
    logic [31:0] stamp;
    logic [31:0] upper;
  } request_t;

  // Laid out to match {out_tuser, out_tdata[50:0]}.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rd_stamp;
    logic [7:0]  rd_refs;
    logic        rd_writing;
    logic        rd_valid;
    logic [4:0]  count;
    logic [3:0]  index;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [3:0] in_tuser = '0;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [1:0] out_tuser;
  logic [55:0] out_tdata;

  event_slot_table_manager uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // Shadow copy of the slot table.
  logic        tbl_valid [NSLOT];
  logic        tbl_writing [NSLOT];
  logic [7:0]  tbl_refs [NSLOT];
  logic [31:0] tbl_stamp [NSLOT];

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int  fail_count = 0;
  bit  hold_sender = 1'b0;
  bit  in_taken = 1'b0;
  int  idle_cycles = 0;

  function automatic reply_t apply_request(request_t r);
    reply_t y;
    bit found;
    int pick;
    logic [31:0] best;
    int n;
    y = '0;
    found = 1'b0;
    pick = 0;
    case (r.func)
      FN_ALLOC: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!tbl_valid[i]) begin
            found = 1'b1;
            pick = i;
            break;
          end
          if (tbl_refs[i] == 0 && !tbl_writing[i] && (!found || tbl_stamp[i] < best)) begin
            found = 1'b1;
            best = tbl_stamp[i];
            pick = i;
          end
        end
        if (found) begin
          tbl_valid[pick] = 1'b1;
          tbl_writing[pick] = 1'b1;
          tbl_refs[pick] = '0;
          tbl_stamp[pick] = '0;
          y.index = pick[3:0];
        end else begin
          y.status = ST_NOTFOUND;
        end
      end
      FN_READY: begin
        tbl_valid[r.slot] = 1'b1;
        tbl_writing[r.slot] = 1'b0;
        tbl_refs[r.slot] = '0;
        tbl_stamp[r.slot] = r.stamp;
      end
      FN_DISCARD: begin
        if (tbl_writing[r.slot]) begin
          tbl_valid[r.slot] = 1'b0;
          tbl_writing[r.slot] = 1'b0;
          tbl_refs[r.slot] = '0;
          tbl_stamp[r.slot] = '0;
        end
      end
      FN_REFSPEC: begin
        if (!(tbl_valid[r.slot] && !tbl_writing[r.slot])) y.status = ST_NOTREADY;
        else if (tbl_refs[r.slot] == 8'hFF) y.status = ST_OVERFLOW;
        else tbl_refs[r.slot]++;
      end
      FN_REFNEXT: begin
        best = r.stamp;
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i] && !tbl_writing[i] && tbl_stamp[i] > best
              && tbl_stamp[i] < r.upper) begin
            found = 1'b1;
            pick = i;
            best = tbl_stamp[i];
          end
        end
        if (!found) begin
          y.status = ST_NOTFOUND;
        end else begin
          y.index = pick[3:0];
          if (tbl_refs[pick] == 8'hFF) y.status = ST_OVERFLOW;
          else tbl_refs[pick]++;
        end
      end
      FN_DEREF: begin
        if (tbl_refs[r.slot] != 0) tbl_refs[r.slot]--;
      end
      FN_COUNT: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_valid[i] && !tbl_writing[i] && tbl_stamp[i] > r.stamp && n < 31) n++;
        y.count = n[4:0];
      end
      FN_READ: begin
        y.rd_valid = tbl_valid[r.slot];
        y.rd_writing = tbl_writing[r.slot];
        y.rd_refs = tbl_refs[r.slot];
        y.rd_stamp = tbl_stamp[r.slot];
      end
      FN_CLRW: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_writing[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_writing[i] = 1'b0;
            tbl_refs[i] = '0;
            tbl_stamp[i] = '0;
          end
        end
      end
      default: y.status = ST_NOTFOUND;
    endcase
    return y;
  endfunction

  function automatic request_t make_req(logic [3:0] f, logic [3:0] s,
                                        logic [31:0] t, logic [31:0] u);
    request_t r;
    r.func = f;
    r.slot = s;
    r.stamp = t;
    r.upper = u;
    return r;
  endfunction

  // Random stamps are drawn mostly from a narrow window so that searches hit.
  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // Sender: bursts with random gaps, fed from the queue of pending requests.
  // Acceptance is seen at the rising edge and acted on at the next falling one.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_replies.push_back(apply_request(pending_requests.pop_front()));
        if (burst_left > 0) burst_left--;
      end
      if (in_tvalid && !in_taken) begin
        // beat still offered, keep it
      end else if (pending_requests.size() == 0 || hold_sender) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (burst_left == 0 && in_tvalid) begin
        gap_left = $urandom_range(0, 40);
        burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b1;
        in_tuser <= pending_requests[0].func;
        in_tdata <= {4'b0, pending_requests[0].upper, pending_requests[0].stamp,
                     pending_requests[0].slot};
      end
    end
  end

  // Receiver stall pattern.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 2000 < 600) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    reply_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[50:0]};
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding");
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); fail_count++;
          end
          if (got.index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, got.index); fail_count++;
          end
          if (got.count !== want.count) begin
            $error("event_count: expected %0d, got %0d", want.count, got.count); fail_count++;
          end
          if (got.rd_valid !== want.rd_valid) begin
            $error("read_valid: expected %0d, got %0d", want.rd_valid, got.rd_valid);
            fail_count++;
          end
          if (got.rd_writing !== want.rd_writing) begin
            $error("read_writing: expected %0d, got %0d", want.rd_writing, got.rd_writing);
            fail_count++;
          end
          if (got.rd_refs !== want.rd_refs) begin
            $error("read_refcount: expected %0d, got %0d", want.rd_refs, got.rd_refs);
            fail_count++;
          end
          if (got.rd_stamp !== want.rd_stamp) begin
            $error("read_stamp: expected %h, got %h", want.rd_stamp, got.rd_stamp);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Pending requests are counted as expected until the sender has passed them on.
  function automatic bit all_settled();
    return pending_requests.size() == 0 && expected_replies.size() == 0 && !in_tvalid;
  endfunction

  initial begin
    request_t r;
    int s;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_writing[i] = 1'b0;
      tbl_refs[i] = '0;
      tbl_stamp[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    pending_requests.push_back(make_req(FN_REFNEXT, 4'd0, 32'd0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(FN_COUNT, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_ALLOC, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_DISCARD, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_DISCARD, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_REFSPEC, 4'd15, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_READY, 4'd15, 32'hFFFF_FFFF, 32'd0));
    pending_requests.push_back(make_req(FN_READY, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_REFNEXT, 4'd0, 32'd0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(FN_COUNT, 4'd0, 32'hFFFF_FFFE, 32'd0));
    pending_requests.push_back(make_req(FN_DEREF, 4'd3, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_ALLOC, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_ALLOC, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_CLRW, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_READ, 4'd15, 32'd0, 32'd0));
    pending_requests.push_back(make_req(4'd9, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(4'd15, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Drive one slot's count to overflow and back.
    for (int k = 0; k < 256; k++)
      pending_requests.push_back(make_req(FN_REFSPEC, 4'd15, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_REFNEXT, 4'd0, 32'd5, 32'd0));
    pending_requests.push_back(make_req(FN_REFNEXT, 4'd0, 32'hFFFF_FFF0, 32'd0));
    pending_requests.push_back(make_req(FN_READ, 4'd15, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_READY, 4'd15, 32'd7, 32'd0));

    // Wait until every reply is back, then hold the sender while the next requests are queued.
    while (!all_settled()) @(posedge clk);
    hold_sender = 1'b1;
    for (int k = 0; k < 16; k++)
      pending_requests.push_back(make_req(FN_ALLOC, 4'd0, 32'd0, 32'd0));
    pending_requests.push_back(make_req(FN_ALLOC, 4'd0, 32'd0, 32'd0));
    hold_sender = 1'b0;

    // Random part: weighted mix of lifecycle requests with some noise.
    for (int k = 0; k < 110; k++) begin
      r.slot = 4'($urandom_range(0, 15));
      r.stamp = rand_stamp();
      r.upper = ($urandom_range(0, 3) == 0) ? $urandom() : rand_stamp();
      s = $urandom_range(0, 99);
      if (s < 15) r.func = FN_ALLOC;
      else if (s < 33) r.func = FN_READY;
      else if (s < 40) r.func = FN_DISCARD;
      else if (s < 52) r.func = FN_REFSPEC;
      else if (s < 64) r.func = FN_REFNEXT;
      else if (s < 74) r.func = FN_DEREF;
      else if (s < 81) r.func = FN_COUNT;
      else if (s < 93) r.func = FN_READ;
      else if (s < 96) r.func = FN_CLRW;
      else r.func = 4'($urandom_range(9, 15));
      pending_requests.push_back(r);
    end

    while (!all_settled()) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
